/* hw/rtl/mntc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed number compare package
// Shared types, codes and widths for the tagged number comparator.
// ----------------------------------------------------------------------------
package mntc_pkg;

    localparam int unsigned BitsW = 64;
    localparam int unsigned ExpW  = 13;   // signed exponent, range -1137..971

    typedef enum logic [1:0] {
        KIND_UNSIGNED = 2'd0,
        KIND_SIGNED   = 2'd1,
        KIND_DOUBLE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    // Operand after decoding, before normalization.
    typedef struct packed {
        logic              neg;
        logic              inf;
        logic              nan;
        logic [BitsW-1:0]  mag;
        logic [ExpW-1:0]   exp;
    } t_raw;

    // Operand after normalization: mag has bit 63 set, or is zero.
    typedef struct packed {
        logic              neg;
        logic              inf;
        logic              nan;
        logic              zero;
        logic [BitsW-1:0]  mag;
        logic [ExpW-1:0]   exp;
    } t_norm;

endpackage

/* hw/rtl/mntc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed number compare channels
// Valid/ready channels for operand pairs and for compare results.
// ----------------------------------------------------------------------------
interface mntc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind_a;
    logic [63:0] bits_a;
    logic [1:0]  kind_b;
    logic [63:0] bits_b;
    modport source (output valid, kind_a, bits_a, kind_b, bits_b, input ready);
    modport sink   (input valid, kind_a, bits_a, kind_b, bits_b, output ready);
endinterface

interface mntc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] order;
    logic       unordered;
    modport source (output valid, order, unordered, input ready);
    modport sink   (input valid, order, unordered, output ready);
endinterface

/* hw/rtl/mntc_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand decoder
// Turns a kind and payload into sign, magnitude and binary exponent.
// ----------------------------------------------------------------------------
module mntc_decode (
    input  logic [1:0]                 i_kind,
    input  logic [mntc_pkg::BitsW-1:0] i_bits,
    output mntc_pkg::t_raw             o_raw
);

    logic [10:0] w_ex;
    logic [51:0] w_fr;

    assign w_ex = i_bits[62:52];
    assign w_fr = i_bits[51:0];

    always_comb begin
        o_raw = '0;
        if (i_kind[1]) begin
            o_raw.neg = i_bits[63];
            if (w_ex == 11'h7ff) begin
                if (w_fr != '0) begin
                    o_raw.nan = 1'b1;
                    o_raw.neg = 1'b0;
                end else begin
                    o_raw.inf = 1'b1;
                end
            end else if (w_ex == 11'd0) begin
                o_raw.mag = {12'd0, w_fr};
                o_raw.exp = -13'sd1074;
            end else begin
                o_raw.mag = {11'd0, 1'b1, w_fr};
                o_raw.exp = {2'b00, w_ex} - 13'd1075;
            end
        end else if (i_kind[0]) begin
            o_raw.neg = i_bits[63];
            o_raw.mag = i_bits[63] ? (64'd0 - i_bits) : i_bits;
        end else begin
            o_raw.mag = i_bits;
        end
    end

endmodule

/* hw/rtl/mntc_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand normalizer
// Shifts the magnitude left until bit 63 is set and adjusts the exponent.
// ----------------------------------------------------------------------------
module mntc_norm (
    input  mntc_pkg::t_raw  i_raw,
    output mntc_pkg::t_norm o_norm
);

    logic [6:0] w_lz;

    // Leading zero count, priority from the top.
    always_comb begin
        w_lz = 7'd0;
        for (int k = 0; k < 64; k++) begin
            if (i_raw.mag[k]) begin
                w_lz = 7'(63 - k);
            end
        end
    end

    always_comb begin
        o_norm.neg  = i_raw.neg && (i_raw.mag != '0 || i_raw.inf);
        o_norm.inf  = i_raw.inf;
        o_norm.nan  = i_raw.nan;
        o_norm.zero = (i_raw.mag == '0) && !i_raw.inf && !i_raw.nan;
        o_norm.mag  = i_raw.mag << w_lz[5:0];
        o_norm.exp  = i_raw.exp - {6'd0, w_lz};
    end

endmodule

/* hw/rtl/mixed_type_number_compare_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed type number compare
// Exact three-way order of two tagged numbers (unsigned, signed or double).
// ----------------------------------------------------------------------------
// Each accepted input beat passes through four registered stages to its result beat.
// Throughput: one pair per cycle; the four stages advance together whenever
// the output register is empty or taken, so nothing is lost on a stall.
// Reset: i_rst_n clears all stage valid bits; payload registers are not reset.
// Stages: decode, normalize, partial compares, final order.
module mixed_type_number_compare_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mntc_in_if.sink     i_in,
    mntc_out_if.source  o_out
);

    // Pipeline advances when the last stage is empty or being drained.
    logic w_adv;
    assign w_adv = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // ---- Stage 1: decode both operands.
    mntc_pkg::t_raw w_raw_a, w_raw_b;
    mntc_pkg::t_raw r_raw_a, r_raw_b;
    logic r_v1;

    mntc_decode u_dec_a (.i_kind(i_in.kind_a), .i_bits(i_in.bits_a), .o_raw(w_raw_a));
    mntc_decode u_dec_b (.i_kind(i_in.kind_b), .i_bits(i_in.bits_b), .o_raw(w_raw_b));

    // ---- Stage 2: normalize.
    mntc_pkg::t_norm w_nrm_a, w_nrm_b;
    mntc_pkg::t_norm r_nrm_a, r_nrm_b;
    logic r_v2;

    mntc_norm u_nrm_a (.i_raw(r_raw_a), .o_norm(w_nrm_a));
    mntc_norm u_nrm_b (.i_raw(r_raw_b), .o_norm(w_nrm_b));

    // ---- Stage 3: independent magnitude compares, registered as flags.
    logic r_v3, r_nan, r_neg_a, r_neg_b;
    logic r_inf_a, r_inf_b, r_zero_a, r_zero_b;
    logic r_exp_gt, r_exp_lt, r_mag_gt, r_mag_lt;

    // ---- Stage 4: output register.
    logic [1:0] r_order;
    logic       r_unord;
    logic       r_v4;

    // Magnitude order as -1/0/+1 coded by less and greater flags.
    logic w_mlt, w_mgt;
    logic [1:0] n_order;

    always_comb begin
        w_mlt = 1'b0;
        w_mgt = 1'b0;
        if (r_inf_a || r_inf_b) begin
            w_mgt = r_inf_a && !r_inf_b;
            w_mlt = r_inf_b && !r_inf_a;
        end else if (r_zero_a || r_zero_b) begin
            w_mgt = !r_zero_a;
            w_mlt = !r_zero_b;
        end else if (r_exp_gt || r_exp_lt) begin
            w_mgt = r_exp_gt;
            w_mlt = r_exp_lt;
        end else begin
            w_mgt = r_mag_gt;
            w_mlt = r_mag_lt;
        end

        if (r_nan) begin
            n_order = mntc_pkg::ORD_EQUAL;
        end else if (r_neg_a && !r_neg_b) begin
            n_order = mntc_pkg::ORD_LESS;
        end else if (!r_neg_a && r_neg_b) begin
            n_order = mntc_pkg::ORD_GREATER;
        end else if (r_neg_a ? w_mgt : w_mlt) begin
            n_order = mntc_pkg::ORD_LESS;
        end else if (r_neg_a ? w_mlt : w_mgt) begin
            n_order = mntc_pkg::ORD_GREATER;
        end else begin
            n_order = mntc_pkg::ORD_EQUAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_raw_a  <= w_raw_a;
            r_raw_b  <= w_raw_b;
            r_nrm_a  <= w_nrm_a;
            r_nrm_b  <= w_nrm_b;
            r_nan    <= r_nrm_a.nan || r_nrm_b.nan;
            r_neg_a  <= r_nrm_a.neg;
            r_neg_b  <= r_nrm_b.neg;
            r_inf_a  <= r_nrm_a.inf;
            r_inf_b  <= r_nrm_b.inf;
            r_zero_a <= r_nrm_a.zero;
            r_zero_b <= r_nrm_b.zero;
            r_exp_gt <= $signed(r_nrm_a.exp) > $signed(r_nrm_b.exp);
            r_exp_lt <= $signed(r_nrm_a.exp) < $signed(r_nrm_b.exp);
            r_mag_gt <= r_nrm_a.mag > r_nrm_b.mag;
            r_mag_lt <= r_nrm_a.mag < r_nrm_b.mag;
            r_order  <= n_order;
            r_unord  <= r_nan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_out.valid     = r_v4;
    assign o_out.order     = r_order;
    assign o_out.unordered = r_unord;

    // An unordered result always reports equal.
    a_nan_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.unordered |-> o_out.order == mntc_pkg::ORD_EQUAL)
        else $error("unordered result not equal");

    // A stalled result holds its order.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.order))
        else $error("stalled result changed");

    // Order code is always one of the three defined values.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.order == mntc_pkg::ORD_LESS ||
                         o_out.order == mntc_pkg::ORD_EQUAL ||
                         o_out.order == mntc_pkg::ORD_GREATER))
        else $error("bad order code");

    // A beat held in stage 3 moves into the output stage when the pipeline advances.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_v3 |=> r_v4)
        else $error("pipeline lost a beat");

endmodule
